/* src/srdz_pkg.sv */
// srdz_pkg: shared types and constants of the radial deadzone block.
// No dependencies; used by every module in src.
`default_nettype none

package srdz_pkg;

    localparam int unsigned ONE_Q    = 32767;
    localparam logic [14:0] DZ_MAX   = 15'd32439;
    localparam logic [22:0] FULL_Q   = 23'h7FFF00;     // 1.0 with 8 fraction bits
    localparam logic [14:0] ONE_Q15  = 15'd32767;
    localparam logic [31:0] ONE_SQ   = 32'd1073676289; // 32767^2
    localparam logic signed [15:0] DIR_TH = 16'sd13107; // 5*v > 65534

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic               dir_right;
        logic               dir_left;
        logic               dir_up;
        logic               dir_down;
    } result_t;

    // travels alongside the square root pipeline
    typedef struct packed {
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic        neg_x;
        logic        neg_y;
        logic        over;
    } sqrt_side_t;

    // travels alongside a divider lane
    typedef struct packed {
        logic neg;
        logic zero;
    } div_side_t;

endpackage

`default_nettype wire

/* src/srdz_sqrt.sv */
// srdz_sqrt: pipelined integer square root of s*65536, one result bit per stage.
// Depends on srdz_pkg.
`default_nettype none

module srdz_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [31:0]        s,
    input  wire srdz_pkg::sqrt_side_t in_side,
    output logic                    out_valid,
    output logic [23:0]             rq,
    output srdz_pkg::sqrt_side_t    out_side
);

    localparam int NSTG = 24;

    logic                 valid_reg [0:NSTG];
    logic [31:0]          s_reg     [0:NSTG];
    logic [26:0]          rem_reg   [0:NSTG];
    logic [23:0]          root_reg  [0:NSTG];
    srdz_pkg::sqrt_side_t side_reg  [0:NSTG];

    always_comb
    begin
        valid_reg[0] = in_valid;
        s_reg[0]     = s;
        rem_reg[0]   = '0;
        root_reg[0]  = '0;
        side_reg[0]  = in_side;
    end

    genvar j;
    generate
        for (j = 0; j < NSTG; j++)
        begin : g_stg
            localparam int BI = NSTG - 1 - j;
            logic [47:0] v;
            logic [26:0] rem_t;
            logic [26:0] trial;
            logic        take;

            always_comb
            begin
                v     = {s_reg[j], 16'h0000};
                rem_t = {rem_reg[j][24:0], v[2*BI+1 -: 2]};
                trial = {1'b0, root_reg[j], 2'b01};
                take  = rem_t >= trial;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j+1] <= 1'b0;
                end
                else
                begin
                    valid_reg[j+1] <= valid_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                s_reg[j+1]    <= s_reg[j];
                side_reg[j+1] <= side_reg[j];
                if (take)
                begin
                    rem_reg[j+1]  <= rem_t - trial;
                    root_reg[j+1] <= {root_reg[j][22:0], 1'b1};
                end
                else
                begin
                    rem_reg[j+1]  <= rem_t;
                    root_reg[j+1] <= {root_reg[j][22:0], 1'b0};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NSTG];
    assign rq        = root_reg[NSTG];
    assign out_side  = side_reg[NSTG];

endmodule

`default_nettype wire

/* src/srdz_div.sv */
// srdz_div: one pipelined restoring divider lane, floor(2N/D) to 17 bits.
// Depends on srdz_pkg. N arrives as num, with 2N = num << 9.
`default_nettype none

module srdz_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [53:0]         num,
    input  wire logic [46:0]         den,
    input  wire srdz_pkg::div_side_t in_side,
    output logic                     out_valid,
    output logic [16:0]              quo,
    output srdz_pkg::div_side_t      out_side
);

    localparam int NSTG = 17;

    logic                valid_reg [0:NSTG];
    logic [46:0]         rem_reg   [0:NSTG];
    logic [46:0]         den_reg   [0:NSTG];
    logic [16:0]         low_reg   [0:NSTG];
    logic [16:0]         quo_reg   [0:NSTG];
    srdz_pkg::div_side_t side_reg  [0:NSTG];

    // top part of 2N is already below D, so only 17 quotient bits remain
    always_comb
    begin
        valid_reg[0] = in_valid;
        rem_reg[0]   = {1'b0, num[53:8]};
        den_reg[0]   = den;
        low_reg[0]   = {num[7:0], 9'h000};
        quo_reg[0]   = '0;
        side_reg[0]  = in_side;
    end

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stg
            logic [47:0] rem_t;
            logic        take;

            always_comb
            begin
                rem_t = {rem_reg[k], low_reg[k][NSTG-1-k]};
                take  = rem_t >= {1'b0, den_reg[k]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else
                begin
                    valid_reg[k+1] <= valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                den_reg[k+1]  <= den_reg[k];
                low_reg[k+1]  <= low_reg[k];
                side_reg[k+1] <= side_reg[k];
                quo_reg[k+1]  <= {quo_reg[k][15:0], take};
                if (take)
                begin
                    rem_reg[k+1] <= 47'(rem_t - {1'b0, den_reg[k]});
                end
                else
                begin
                    rem_reg[k+1] <= rem_t[46:0];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NSTG];
    assign quo       = quo_reg[NSTG];
    assign out_side  = side_reg[NSTG];

endmodule

`default_nettype wire

/* src/stick_radial_deadzone.sv */
// stick_radial_deadzone: top level, input conditioning, rescale setup, output stage.
// Depends on srdz_pkg, srdz_sqrt, srdz_div.
`default_nettype none

// One (raw_x, raw_y) item is taken in every clock cycle: busy is always low.
// Each item gives one result, shown on result with result_valid for one
// cycle, in the order taken. An item passes through the 24-stage square
// root and the 17-stage divider lanes, plus six register stages around
// them. The receiver cannot stall. Write deadzone only while no item is in flight.
module stick_radial_deadzone (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire srdz_pkg::sample_t sample,
    input  wire logic              cfg_we,
    input  wire logic [14:0]       cfg_wdata,
    output logic                   result_valid,
    output srdz_pkg::result_t      result
);

    logic [14:0] deadzone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= '0;
        end
        else if (cfg_we)
        begin
            deadzone_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // stage 1: magnitudes and signs, y inverted and saturated
    logic                 s1_valid_reg;
    srdz_pkg::sqrt_side_t s1_side_reg;
    srdz_pkg::sqrt_side_t s1_side_next;

    always_comb
    begin
        s1_side_next.mag_x = sample.raw_x[15] ? 16'(-sample.raw_x) : sample.raw_x;
        s1_side_next.neg_x = sample.raw_x[15];
        if (sample.raw_y == 16'sh8000)
        begin
            s1_side_next.mag_y = 16'd32767;
        end
        else
        begin
            s1_side_next.mag_y = sample.raw_y[15] ? 16'(-sample.raw_y) : sample.raw_y;
        end
        s1_side_next.neg_y = !sample.raw_y[15] && (sample.raw_y != 16'sd0);
        s1_side_next.over  = 1'b0;
    end

    // stage 2: squares; stage 3: sum and circle check
    logic                 s2_valid_reg;
    srdz_pkg::sqrt_side_t s2_side_reg;
    logic [31:0]          sqx_reg;
    logic [31:0]          sqy_reg;
    logic                 s3_valid_reg;
    srdz_pkg::sqrt_side_t s3_side_reg;
    logic [31:0]          s_reg;
    logic [32:0]          sum;

    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg <= s1_side_next;
        s2_side_reg <= s1_side_reg;
        sqx_reg     <= s1_side_reg.mag_x * s1_side_reg.mag_x;
        sqy_reg     <= s1_side_reg.mag_y * s1_side_reg.mag_y;
        s3_side_reg <= '{mag_x: s2_side_reg.mag_x, mag_y: s2_side_reg.mag_y,
                         neg_x: s2_side_reg.neg_x, neg_y: s2_side_reg.neg_y,
                         over: sum[31:0] > srdz_pkg::ONE_SQ};
        s_reg       <= sum[31:0];
    end

    logic                 sq_valid;
    logic [23:0]          sq_rq;
    srdz_pkg::sqrt_side_t sq_side;

    srdz_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .s         (s_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_valid),
        .rq        (sq_rq),
        .out_side  (sq_side)
    );

    // stage A: clamp radius, deadzone test, factor setup
    logic [14:0] dz_eff;
    logic [22:0] dzq;
    logic [22:0] rc;

    assign dz_eff = (deadzone_reg > srdz_pkg::DZ_MAX) ? srdz_pkg::DZ_MAX : deadzone_reg;
    assign dzq    = {dz_eff, 8'h00};
    assign rc     = sq_side.over ? srdz_pkg::FULL_Q : sq_rq[22:0];

    logic        sa_valid_reg;
    logic [23:0] sa_rq_reg;
    logic [22:0] sa_dn_reg;
    logic [22:0] sa_fd_reg;
    logic [30:0] sa_ax_reg;
    logic [30:0] sa_ay_reg;
    logic        sa_zero_reg;
    logic        sa_negx_reg;
    logic        sa_negy_reg;

    // stage B: numerators and denominator
    logic        sb_valid_reg;
    logic [46:0] sb_den_reg;
    logic [53:0] sb_nx_reg;
    logic [53:0] sb_ny_reg;
    logic        sb_zero_reg;
    logic        sb_negx_reg;
    logic        sb_negy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
        end
        else
        begin
            sa_valid_reg <= sq_valid;
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_rq_reg   <= sq_rq;
        sa_dn_reg   <= rc - dzq;
        sa_fd_reg   <= srdz_pkg::FULL_Q - dzq;
        sa_ax_reg   <= sq_side.mag_x * srdz_pkg::ONE_Q15;
        sa_ay_reg   <= sq_side.mag_y * srdz_pkg::ONE_Q15;
        sa_zero_reg <= rc <= dzq;
        sa_negx_reg <= sq_side.neg_x;
        sa_negy_reg <= sq_side.neg_y;
        sb_den_reg  <= sa_rq_reg * sa_fd_reg;
        sb_nx_reg   <= sa_ax_reg * sa_dn_reg;
        sb_ny_reg   <= sa_ay_reg * sa_dn_reg;
        sb_zero_reg <= sa_zero_reg;
        sb_negx_reg <= sa_negx_reg;
        sb_negy_reg <= sa_negy_reg;
    end

    srdz_pkg::div_side_t dx_in;
    srdz_pkg::div_side_t dy_in;
    srdz_pkg::div_side_t dx_out;
    srdz_pkg::div_side_t dy_out;
    logic                dx_valid;
    logic                dy_valid;
    logic [16:0]         qx;
    logic [16:0]         qy;

    assign dx_in = '{neg: sb_negx_reg, zero: sb_zero_reg};
    assign dy_in = '{neg: sb_negy_reg, zero: sb_zero_reg};

    srdz_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sb_valid_reg),
        .num       (sb_nx_reg),
        .den       (sb_den_reg),
        .in_side   (dx_in),
        .out_valid (dx_valid),
        .quo       (qx),
        .out_side  (dx_out)
    );

    srdz_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sb_valid_reg),
        .num       (sb_ny_reg),
        .den       (sb_den_reg),
        .in_side   (dy_in),
        .out_valid (dy_valid),
        .quo       (qy),
        .out_side  (dy_out)
    );

    // output stage: round half away, saturate, sign, flags
    logic [17:0]        rx;
    logic [17:0]        ry;
    logic [14:0]        mx;
    logic [14:0]        my;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    srdz_pkg::result_t  result_next;

    always_comb
    begin
        rx = {1'b0, qx} + 18'd1;
        ry = {1'b0, qy} + 18'd1;
        mx = (rx[17:1] > 17'(srdz_pkg::ONE_Q)) ? srdz_pkg::ONE_Q15 : rx[15:1];
        my = (ry[17:1] > 17'(srdz_pkg::ONE_Q)) ? srdz_pkg::ONE_Q15 : ry[15:1];
        if (dx_out.zero)
        begin
            mx = '0;
            my = '0;
        end
        ox = dx_out.neg ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
        oy = dy_out.neg ? -$signed({1'b0, my}) : $signed({1'b0, my});
        result_next.out_x     = ox;
        result_next.out_y     = oy;
        result_next.dir_right = ox >= srdz_pkg::DIR_TH;
        result_next.dir_left  = ox <= -srdz_pkg::DIR_TH;
        result_next.dir_up    = oy >= srdz_pkg::DIR_TH;
        result_next.dir_down  = oy <= -srdz_pkg::DIR_TH;
    end

    logic result_valid_reg;
    srdz_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= dx_valid && dy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* src/srdz_chk.sv */
// srdz_chk: port-level checks of stick_radial_deadzone, bound to the top level.
// Depends on srdz_pkg.
`default_nettype none

module srdz_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              result_valid,
    input wire srdz_pkg::result_t result
);

    // every result comes from an item started a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 47))
        else $error("result without matching item");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_x != 16'sh8000) && (result.out_y != 16'sh8000))
        else $error("output out of range");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.dir_right == (result.out_x >= srdz_pkg::DIR_TH)) &&
                         (result.dir_down == (result.out_y <= -srdz_pkg::DIR_TH)) &&
                         !(result.dir_left && result.dir_right) &&
                         !(result.dir_up && result.dir_down))
        else $error("direction flags inconsistent");

endmodule

bind stick_radial_deadzone srdz_chk u_srdz_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

/* tb/srdz_checker.sv */
// srdz_checker: watches the sample and result channels of stick_radial_deadzone,
// predicts each conditioned result and compares it field by field.
// Depends on srdz_pkg.
module srdz_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire srdz_pkg::sample_t sample,
    input  wire logic              cfg_we,
    input  wire logic [14:0]       cfg_wdata,
    input  wire logic              result_valid,
    input  wire srdz_pkg::result_t result,
    output int                     errors,
    output int                     pending,
    output int                     n_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [14:0]       dz_reg;
    srdz_pkg::result_t expected_q[$];

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int scale_axis(int c, longint unsigned rq, longint unsigned rc,
                                      longint unsigned dzq);
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        mag = (c < 0) ? -c : c;
        num = 64'd32767 * (mag << 8) * (rc - dzq);
        den = rq * ((64'd32767 << 8) - dzq);
        q = (2 * num + den) / (2 * den);
        if (q > 32767)
            q = 32767;
        return (c < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic srdz_pkg::result_t condition_stick(srdz_pkg::sample_t s,
                                                          logic [14:0] dz_in);
        srdz_pkg::result_t r;
        int                x;
        int                y;
        int                ox;
        int                oy;
        longint unsigned   dz;
        longint unsigned   sq;
        longint unsigned   rq;
        longint unsigned   rc;
        x = s.raw_x;
        y = -int'(s.raw_y);
        if (y > 32767)
            y = 32767;
        dz = (dz_in > srdz_pkg::DZ_MAX) ? srdz_pkg::DZ_MAX : dz_in;
        sq = longint'(x) * x + longint'(y) * y;
        rq = sqrt_floor(sq << 16);
        rc = (sq > 64'd1073676289) ? (64'd32767 << 8) : rq;
        ox = 0;
        oy = 0;
        if (rc > (dz << 8))
        begin
            ox = scale_axis(x, rq, rc, dz << 8);
            oy = scale_axis(y, rq, rc, dz << 8);
        end
        r.out_x = ox[15:0];
        r.out_y = oy[15:0];
        r.dir_right = 5 * ox > 65534;
        r.dir_left  = 5 * ox < -65534;
        r.dir_up    = 5 * oy > 65534;
        r.dir_down  = 5 * oy < -65534;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg = '0;
            errors = 0;
            n_results = 0;
            expected_q.delete();
        end
        else
        begin
            if (result_valid)
            begin
                n_results++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", result);
                end
                else
                begin
                    srdz_pkg::result_t e;
                    e = expected_q.pop_front();
                    if (e.out_x !== result.out_x || e.out_y !== result.out_y ||
                        e.dir_right !== result.dir_right || e.dir_left !== result.dir_left ||
                        e.dir_up !== result.dir_up || e.dir_down !== result.dir_down)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp x=%0d y=%0d rlud=%b%b%b%b",
                                     e.out_x, e.out_y, e.dir_right, e.dir_left, e.dir_up,
                                     e.dir_down, " got x=%0d y=%0d rlud=%b%b%b%b",
                                     result.out_x, result.out_y, result.dir_right,
                                     result.dir_left, result.dir_up, result.dir_down);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(condition_stick(sample, dz_reg));
            if (cfg_we)
                dz_reg = cfg_wdata;
        end
    end
endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for stick_radial_deadzone.
// Depends on srdz_pkg, stick_radial_deadzone and srdz_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 47;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    srdz_pkg::sample_t sample;
    logic              cfg_we;
    logic [14:0]       cfg_wdata;
    logic              result_valid;
    srdz_pkg::result_t result;
    int                errors;
    int                pending;
    int                n_results;
    int                idle_cycles;
    int                n_items;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    stick_radial_deadzone i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_valid(result_valid),
        .result(result)
    );

    srdz_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_valid(result_valid),
        .result(result), .errors(errors), .pending(pending), .n_results(n_results)
    );

    // watchdog: cycles without an accepted item or result
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one item, held until accepted; idle_pct sets the gap odds
    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y, int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
        start <= 1'b1;
        sample <= '{raw_x: x, raw_y: y};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_items++;
        @(negedge clk);
    endtask

    task automatic drain_and_set(logic [14:0] dz);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 3) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= dz;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(600)) - 16'd300;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] edge_vals[7];
        int                 idle_pct;
        logic [14:0]        dz_set[8];
        idle_cycles = 0;
        n_items = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: axis extremes, zero, both negated-minimum cases, default deadzone
        edge_vals = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1, 16'sd13107, -16'sd13107};
        for (int i = 0; i < 7; i++)
            for (int j = 0; j < 3; j++)
                send_sample(edge_vals[i], edge_vals[(i + j * 2) % 7], 0);
        drain_and_set(15'h7FFF);    // above the cap, acts as 0.99
        send_sample(16'sh7FFF, 16'sh8000, 0);
        send_sample(16'sd32000, 16'sd0, 0);
        send_sample(16'sd100, -16'sd100, 0);

        dz_set = '{15'd0, 15'd32439, 15'd32440, 15'd8000, 15'd1, 15'd16384, 15'd3000, 15'd0};
        for (int ph = 0; ph < 8; ph++)
        begin
            drain_and_set(ph == 7 ? 15'($urandom) : dz_set[ph]);
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 84;
                2: idle_pct = 0;
                default: idle_pct = 13;
            endcase
            for (int k = 0; k < 135; k++)
                send_sample(rand_axis(), rand_axis(), idle_pct);
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        $display("ran %0d stick samples over 10 deadzone settings, %0d results checked",
                 n_items, n_results);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* sim.f */
src/srdz_pkg.sv
src/srdz_sqrt.sv
src/srdz_div.sv
src/stick_radial_deadzone.sv
src/srdz_chk.sv
tb/srdz_checker.sv
tb/tb.sv
